[rtl/d2i_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// d2i_pkg
// shared widths and operation codes for the double to integer converter
// ---------------------------------------------------------------------------
package d2i_pkg;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 64;
   localparam int INT_W   = 64;
   localparam int EXP_W   = 11;
   localparam int FRAC_W  = 52;

   localparam logic [OP_W-1:0] OP_ROUND16 = 2'd0;
   localparam logic [OP_W-1:0] OP_ROUND32 = 2'd1;
   localparam logic [OP_W-1:0] OP_TRUNC64 = 2'd2;

   // exponent at which the significand lsb weighs one
   localparam logic [EXP_W-1:0] EXP_UNIT     = 11'd1075;
   localparam logic [EXP_W-1:0] EXP_SAT      = 11'd1086;
   localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;

endpackage

[rtl/d2i_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// d2i_core
// combinational conversion of one binary64 word to a signed integer
// ---------------------------------------------------------------------------
module d2i_core
   import d2i_pkg::*;
(
   input  logic [OP_W-1:0]    op,
   input  logic [VALUE_W-1:0] value_bits,
   output logic [INT_W-1:0]   int_result,
   output logic               ok
);

   logic              neg;
   logic [EXP_W-1:0]  exp_raw;
   logic [EXP_W-1:0]  exp_eff;
   logic [FRAC_W:0]   sig;
   logic              is_nan;
   logic [EXP_W-1:0]  rsh;
   logic [5:0]        rsh6;
   logic              rsh_big;
   logic [FRAC_W:0]   rem;
   logic [FRAC_W:0]   half;
   logic [FRAC_W:0]   mask;
   logic [FRAC_W:0]   q_rnd;
   logic [FRAC_W:0]   q_trunc;
   logic [3:0]        lsh;
   logic [INT_W-1:0]  mag_big;
   logic [INT_W-1:0]  mag_t;
   logic [FRAC_W:0]   lim16;
   logic [FRAC_W:0]   lim32;
   logic [FRAC_W:0]   lim;
   logic [INT_W-1:0]  q_ext;

   // decode sign, effective exponent, significand
   always_comb begin
      neg     = value_bits[63];
      exp_raw = value_bits[62:52];
      exp_eff = (exp_raw == '0) ? 11'd1 : exp_raw;
      sig     = {(exp_raw != '0), value_bits[FRAC_W-1:0]};
      is_nan  = (exp_raw == EXP_ALL_ONES) && (value_bits[FRAC_W-1:0] != '0);
   end

   // right shift for magnitudes below 2^52, sticky shift amounts over 63 clear
   always_comb begin
      rsh     = EXP_UNIT - exp_eff;
      rsh_big = (rsh > 11'd63);
      rsh6    = rsh[5:0];
      mask    = (rsh6 >= 6'd53) ? '1 : ((53'd1 << rsh6) - 53'd1);
      half    = (rsh6 >= 6'd54) ? '0 : (53'd1 << (rsh6 - 6'd1));
      q_trunc = (rsh_big || rsh6 >= 6'd53) ? '0 : (sig >> rsh6);
      rem     = sig & mask;
      q_rnd   = q_trunc;
      if (!rsh_big && ((rem > half && half != '0) ||
                       (rem == half && half != '0 && q_trunc[0]))) begin
         q_rnd = q_trunc + 53'd1;
      end
      if (rsh_big) begin
         q_rnd = '0;
      end
   end

   // left shift for magnitudes 2^52 to 2^63
   always_comb begin
      lsh     = 4'(exp_eff - EXP_UNIT);
      mag_big = {11'd0, sig} << lsh;
      mag_t   = (exp_eff >= EXP_UNIT) ? mag_big : {11'd0, q_trunc};
   end

   // range check and result select
   always_comb begin
      lim16 = neg ? 53'd32768 : 53'd32767;
      lim32 = neg ? 53'd2147483648 : 53'd2147483647;
      lim   = (op == OP_ROUND16) ? lim16 : lim32;
      q_ext = {11'd0, q_rnd};
      int_result = '0;
      ok         = 1'b0;
      case (op) inside
         OP_ROUND16, OP_ROUND32: begin
            if (exp_raw != EXP_ALL_ONES && exp_eff < EXP_UNIT && q_rnd <= lim) begin
               int_result = neg ? (64'd0 - q_ext) : q_ext;
               ok         = 1'b1;
            end
         end
         OP_TRUNC64: begin
            ok = 1'b1;
            if (is_nan) begin
               int_result = '0;
            end else if (exp_eff >= EXP_SAT) begin
               int_result = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            end else begin
               int_result = neg ? (64'd0 - mag_t) : mag_t;
            end
         end
         default: begin
            int_result = '0;
            ok         = 1'b0;
         end
      endcase
   end

endmodule

[rtl/double_to_int_convert.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_to_int_convert
// converts a raw binary64 word to a checked or saturating signed integer
// ---------------------------------------------------------------------------
// usage:
//   a word is taken at a clock edge with start high and busy low; busy
//   is tied low, so a new word can enter on every cycle
//   req_op selects round-even to int16 (checked), round-even to int32
//   (checked) or truncate to int64 (saturating)
//   the word is registered at the input, converted by one pass of decode,
//   shift, round and range logic, and registered at the output
//   throughput: 1 word per cycle
//   rsp_valid is high for exactly one cycle per word; the receiver cannot
//   stall, so results are never held back
//   reset clears both valid flags; payload registers are not reset
// ---------------------------------------------------------------------------
module double_to_int_convert
   import d2i_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [VALUE_W-1:0]  req_value_bits,
   output logic                rsp_valid,
   output logic signed [INT_W-1:0] rsp_int_result,
   output logic                rsp_ok
);

   logic                in_vld_ff;
   logic [OP_W-1:0]     op_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic                out_vld_ff;
   logic [INT_W-1:0]    res_ff;
   logic                ok_ff;
   logic [INT_W-1:0]    res_in;
   logic                ok_in;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start;
      end
      op_ff  <= req_op;
      val_ff <= req_value_bits;
   end

   d2i_core u_core (
      .op         (op_ff),
      .value_bits (val_ff),
      .int_result (res_in),
      .ok         (ok_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= in_vld_ff;
      end
      res_ff <= res_in;
      ok_ff  <= ok_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_int_result = res_ff;
   assign rsp_ok         = ok_ff;

endmodule

[rtl/d2i_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// d2i_checker
// port level checks for the double to integer converter
// ---------------------------------------------------------------------------
module d2i_checker
   import d2i_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [INT_W-1:0]   rsp_int_result,
   input logic               rsp_ok
);

   // each accepted word gives a result after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("missing result");

   // no result without an accepted word
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("unexpected result");

   // a failed conversion reports zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_int_result == '0))
      else $error("nonzero failed result");

   // the converter never stalls
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy asserted");

endmodule

bind double_to_int_convert d2i_checker u_d2i_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_int_result (rsp_int_result),
   .rsp_ok         (rsp_ok)
);
